@@ hdl/backlight_fade_ramp_unit_macros.svh @@
// assertion macros used by the checker of the fade ramp unit
`ifndef BACKLIGHT_FADE_RAMP_UNIT_MACROS_SVH
`define BACKLIGHT_FADE_RAMP_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while reset is asserted
`define BFR_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while reset is asserted
`define BFR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/bfr_pkg.sv @@
package bfr_pkg;

	// widths fixed by the stream fields
	localparam int DUR_BITS        = 16;
	localparam int LEVEL_BITS_DEF  = 16;
	localparam int TIME_BITS_DEF   = 32;

	// input opcodes
	localparam logic OP_SET  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// register indexes (word address)
	localparam logic [1:0] REG_BACKLIGHT = 2'd0;
	localparam logic [1:0] REG_POWER     = 2'd1;
	localparam logic [1:0] REG_MIN_FADE  = 2'd2;

	localparam logic [DUR_BITS-1:0] MIN_FADE_RST = 16'd20;

	// kind of write carried by a result
	typedef enum logic [1:0] {
		KIND_LEVEL   = 2'd0,
		KIND_UNBLANK = 2'd1,
		KIND_DOWN    = 2'd2
	} kind_t;

endpackage

@@ hdl/bfr_mul.sv @@
module bfr_mul #(
	parameter int LEVEL_BITS = bfr_pkg::LEVEL_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [LEVEL_BITS-1:0]                   mag,
	input  logic [bfr_pkg::DUR_BITS-1:0]            mult,
	output logic                                    done,
	output logic [LEVEL_BITS+bfr_pkg::DUR_BITS-1:0] prod
);
	import bfr_pkg::*;

	localparam int PW = LEVEL_BITS + DUR_BITS;
	localparam int CW = $clog2(DUR_BITS + 1);

	logic [PW-1:0]         acc_q;
	logic [DUR_BITS-1:0]   mult_q;
	logic [LEVEL_BITS-1:0] mag_q;
	logic [CW-1:0]         cnt_q;
	logic                  run_q;
	logic                  done_q;

	// step counter, one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DUR_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add, multiplier msb first
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			mult_q <= mult;
			mag_q  <= mag;
		end else if (run_q) begin
			acc_q  <= {acc_q[PW-2:0], 1'b0} + (mult_q[DUR_BITS-1] ? PW'(mag_q) : '0);
			mult_q <= {mult_q[DUR_BITS-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ hdl/bfr_div.sv @@
module bfr_div #(
	parameter int LEVEL_BITS = bfr_pkg::LEVEL_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [LEVEL_BITS+bfr_pkg::DUR_BITS-1:0] prod,
	input  logic [bfr_pkg::DUR_BITS-1:0]            dur,
	output logic                                    done,
	output logic [LEVEL_BITS-1:0]                   quot
);
	import bfr_pkg::*;

	localparam int PW = LEVEL_BITS + DUR_BITS;
	localparam int NW = PW + 2;
	localparam int RW = DUR_BITS + 1;
	localparam int CW = $clog2(LEVEL_BITS + 1);

	logic [NW-1:0]         num;
	logic [RW-1:0]         rem_q;
	logic [RW-1:0]         dvs_q;
	logic [LEVEL_BITS-1:0] num_q;
	logic [CW-1:0]         cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [RW:0]           trial;
	logic [RW:0]           diff;
	logic                  ge;

	// rounded numerator 2*prod + dur, divisor 2*dur
	assign num = NW'({prod, 1'b0}) + NW'(dur);

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, num_q[LEVEL_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(LEVEL_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient fits the level width, so the top bits preload the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[LEVEL_BITS+RW-1:LEVEL_BITS];
			num_q <= num[LEVEL_BITS-1:0];
			dvs_q <= {dur, 1'b0};
		end else if (run_q) begin
			rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
			num_q <= {num_q[LEVEL_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

@@ hdl/backlight_fade_ramp_unit.sv @@
// set request without a fade: results pass through ST_DECIDE, then
// ST_UNBLANK or ST_LEVEL into the result register; a set that starts a fade
// or keeps the level writes nothing; a tick before the fade ends runs the
// 16-step serial multiply and then the LEVEL_BITS-step serial divide
// one item at a time; the next item is taken once the last result is registered
// async reset: level 0, no fade, backlight and power control present, min fade 20
module backlight_fade_ramp_unit #(
	parameter int LEVEL_BITS = bfr_pkg::LEVEL_BITS_DEF,
	parameter int TIME_BITS  = bfr_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // target_level[15:0], fade_ms[31:16], now_ms[63:32]
	input  logic        s_tuser,   // opcode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // write_value[15:0], fade_active[16], zero[23:17]
	output logic [1:0]  m_tuser,   // write_kind
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bfr_pkg::*;

	localparam int PW = LEVEL_BITS + DUR_BITS;

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_CHECK   = 8'b0000_0010,
		ST_MUL     = 8'b0000_0100,
		ST_DIV     = 8'b0000_1000,
		ST_DECIDE  = 8'b0001_0000,
		ST_UNBLANK = 8'b0010_0000,
		ST_LEVEL   = 8'b0100_0000,
		ST_DOWN    = 8'b1000_0000
	} state_t;

	state_t                state_q;
	logic                  backlight_q;
	logic                  power_q;
	logic [DUR_BITS-1:0]   min_fade_q;
	logic [LEVEL_BITS-1:0] cur_q;
	logic [LEVEL_BITS-1:0] start_lvl_q;
	logic [LEVEL_BITS-1:0] end_lvl_q;
	logic [TIME_BITS-1:0]  start_time_q;
	logic [DUR_BITS-1:0]   dur_q;
	logic                  fading_q;
	logic [TIME_BITS-1:0]  elapsed_q;
	logic [LEVEL_BITS-1:0] new_lvl_q;
	logic                  down_q;
	logic                  out_valid_q;
	kind_t                 out_kind_q;
	logic [15:0]           out_value_q;
	logic                  out_last_q;
	logic                  out_active_q;

	logic                  in_xfer;
	logic                  cfg_wr;
	logic                  out_free;
	logic                  out_load;
	logic                  opcode;
	logic [LEVEL_BITS-1:0] tgt;
	logic [DUR_BITS-1:0]   fade_ms;
	logic [TIME_BITS-1:0]  now_t;
	logic [31:0]           tgt_wide;
	logic [63:0]           now_wide;
	logic [31:0]           new_wide;
	logic                  time_up;
	logic                  ramp_down;
	logic [LEVEL_BITS-1:0] mag;
	logic                  mul_start;
	logic                  mul_done;
	logic [PW-1:0]         prod;
	logic                  div_start;
	logic                  div_done;
	logic [LEVEL_BITS-1:0] quot;
	logic                  down_after;

	// unpack input fields, kept to the configured widths
	assign opcode   = s_tuser;
	assign tgt_wide = 32'(s_tdata[15:0]);
	assign tgt      = tgt_wide[LEVEL_BITS-1:0];
	assign fade_ms  = s_tdata[31:16];
	assign now_wide = 64'(s_tdata[63:32]);
	assign now_t    = now_wide[TIME_BITS-1:0];

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = out_free
		&& (state_q == ST_UNBLANK || state_q == ST_LEVEL || state_q == ST_DOWN);
	assign cfg_wr   = psel && penable && pwrite && pready;

	// ramp direction and size
	assign time_up   = (dur_q == '0) || (elapsed_q >= TIME_BITS'(dur_q));
	assign ramp_down = end_lvl_q < start_lvl_q;
	assign mag       = ramp_down ? start_lvl_q - end_lvl_q : end_lvl_q - start_lvl_q;
	assign mul_start = (state_q == ST_CHECK) && !time_up;
	assign div_start = (state_q == ST_MUL) && mul_done;

	assign new_wide   = 32'(new_lvl_q);
	assign down_after = (new_lvl_q == '0) && power_q;

	bfr_mul #(
		.LEVEL_BITS(LEVEL_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.mag   (mag),
		.mult  (elapsed_q[DUR_BITS-1:0]),
		.done  (mul_done),
		.prod  (prod)
	);

	bfr_div #(
		.LEVEL_BITS(LEVEL_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.prod  (prod),
		.dur   (dur_q),
		.done  (div_done),
		.quot  (quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= 1'b1;
			power_q     <= 1'b1;
			min_fade_q  <= MIN_FADE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_BACKLIGHT: backlight_q <= pwdata[0];
				REG_POWER:     power_q     <= pwdata[0];
				REG_MIN_FADE:  min_fade_q  <= pwdata[DUR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			REG_BACKLIGHT: prdata = 32'(backlight_q);
			REG_POWER:     prdata = 32'(power_q);
			REG_MIN_FADE:  prdata = 32'(min_fade_q);
			default:       prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// sequencer, ramp state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			start_lvl_q  <= '0;
			end_lvl_q    <= '0;
			start_time_q <= '0;
			dur_q        <= '0;
			fading_q     <= 1'b0;
			elapsed_q    <= '0;
			new_lvl_q    <= '0;
			down_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_LEVEL;
			out_value_q  <= '0;
			out_last_q   <= 1'b0;
			out_active_q <= 1'b0;
		end else begin
			if (m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && backlight_q) begin
						if (opcode == OP_SET) begin
							if (tgt == cur_q || fade_ms <= min_fade_q) begin
								// cancel any fade, write at once if the level moves
								fading_q     <= 1'b0;
								start_time_q <= '0;
								dur_q        <= '0;
								start_lvl_q  <= cur_q;
								end_lvl_q    <= cur_q;
								new_lvl_q    <= tgt;
								state_q      <= (tgt == cur_q) ? ST_IDLE : ST_DECIDE;
							end else begin
								start_time_q <= now_t;
								dur_q        <= fade_ms;
								start_lvl_q  <= cur_q;
								end_lvl_q    <= tgt;
								fading_q     <= 1'b1;
							end
						end else if (fading_q) begin
							elapsed_q <= now_t - start_time_q;
							state_q   <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					down_q <= ramp_down;
					if (time_up) begin
						new_lvl_q <= end_lvl_q;
						fading_q  <= 1'b0;
						state_q   <= ST_DECIDE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						new_lvl_q <= down_q ? start_lvl_q - quot : start_lvl_q + quot;
						state_q   <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (new_lvl_q == cur_q) begin
						state_q <= ST_IDLE;
					end else if (cur_q == '0 && power_q) begin
						state_q <= ST_UNBLANK;
					end else begin
						state_q <= ST_LEVEL;
					end
				end
				ST_UNBLANK: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= KIND_UNBLANK;
						out_value_q  <= '0;
						out_last_q   <= 1'b0;
						out_active_q <= fading_q;
						state_q      <= ST_LEVEL;
					end
				end
				ST_LEVEL: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= KIND_LEVEL;
						out_value_q  <= new_wide[15:0];
						out_last_q   <= !down_after;
						out_active_q <= fading_q;
						cur_q        <= new_lvl_q;
						state_q      <= down_after ? ST_DOWN : ST_IDLE;
					end
				end
				ST_DOWN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_kind_q   <= KIND_DOWN;
						out_value_q  <= '0;
						out_last_q   <= 1'b1;
						out_active_q <= fading_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result stream
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_active_q, out_value_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

@@ hdl/bfr_chk.sv @@
`include "backlight_fade_ramp_unit_macros.svh"

module bfr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import bfr_pkg::*;

	// a stalled result keeps its payload
	`BFR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// power writes carry a zero level
	`BFR_ASSERT_NOW(a_pwr_zero, m_tvalid && m_tuser != KIND_LEVEL, m_tdata[15:0] == 16'd0, "power write with nonzero value")

	// power-down always closes the run
	`BFR_ASSERT_NOW(a_down_last, m_tvalid && m_tuser == KIND_DOWN, m_tlast, "power down not last")

	// unblank is never marked last, as a level write always follows it
	`BFR_ASSERT_NOW(a_unblank_first, m_tvalid && m_tuser == KIND_UNBLANK, !m_tlast, "unblank marked last")

	// only the three defined write kinds appear
	`BFR_ASSERT_NOW(a_kind_legal, m_tvalid, m_tuser == KIND_LEVEL || m_tuser == KIND_UNBLANK || m_tuser == KIND_DOWN, "unknown write kind")

endmodule

bind backlight_fade_ramp_unit bfr_chk u_chk (.*);
